[hdl/mfw_pkg.sv]
// Shared types and constants for the motion fault watchdog.
package mfw_pkg;

    // Control mode carried by each item
    typedef enum logic [1:0] {
        MODE_TRACK = 2'd0,
        MODE_SIDE  = 2'd1,
        MODE_FRONT = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SPEED_LIMIT   = 2'd0,
        CFG_ANGLE_LIMIT   = 2'd1,
        CFG_PERSIST_LIMIT = 2'd2,
        CFG_FRONT_LIMIT   = 2'd3
    } cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the limit registers
    localparam logic [15:0] SPEED_LIMIT_RST   = 16'd512;
    localparam logic [15:0] ANGLE_LIMIT_RST   = 16'd512;
    localparam logic [7:0]  PERSIST_LIMIT_RST = 8'd100;
    localparam logic [15:0] FRONT_LIMIT_RST   = 16'd1000;

    // Counter saturation points
    localparam logic [7:0]  DEV_TICKS_MAX   = 8'd255;
    localparam logic [15:0] FRONT_TICKS_MAX = 16'd65535;

    // Current limit settings
    typedef struct packed {
        logic [15:0] speed_error_limit;
        logic [15:0] angle_error_limit;
        logic [7:0]  persist_limit;
        logic [15:0] front_time_limit;
    } cfg_t;

    // One control tick
    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
        logic signed [15:0] target_angle;
        logic signed [15:0] measured_angle;
    } item_t;

endpackage

[hdl/mfw_cfg.sv]
// Limit register file written through the configuration port.
module mfw_cfg
    import mfw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPEED_LIMIT:   cfg_next.speed_error_limit = cfg_data;
                CFG_ANGLE_LIMIT:   cfg_next.angle_error_limit = cfg_data;
                CFG_PERSIST_LIMIT: cfg_next.persist_limit     = cfg_data[7:0];
                CFG_FRONT_LIMIT:   cfg_next.front_time_limit  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_error_limit <= SPEED_LIMIT_RST;
            cfg_reg.angle_error_limit <= ANGLE_LIMIT_RST;
            cfg_reg.persist_limit     <= PERSIST_LIMIT_RST;
            cfg_reg.front_time_limit  <= FRONT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/mfw_eval.sv]
// Fault evaluation for one tick and the persistence / time counters.
module mfw_eval
    import mfw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  fault_next
);

    logic [7:0]  speed_dev_ticks_reg;
    logic [7:0]  speed_dev_ticks_next;
    logic [7:0]  angle_dev_ticks_reg;
    logic [7:0]  angle_dev_ticks_next;
    logic [15:0] front_mode_ticks_reg;
    logic [15:0] front_mode_ticks_next;

    logic [15:0] speed_err;
    logic [15:0] angle_err;
    logic        speed_over;
    logic        angle_over;
    logic [7:0]  speed_cnt;
    logic [7:0]  angle_cnt;
    logic [15:0] front_cnt;
    logic        speed_fault;
    logic        angle_fault;
    logic        front_fault;

    // |a - b| of two signed 16-bit values; always fits 16 bits unsigned
    function automatic logic [15:0] abs_err(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
        logic signed [16:0] d;
        logic signed [16:0] m;
        d = 17'(a) - 17'(b);
        m = d[16] ? -d : d;
        return m[15:0];
    endfunction

    // Error magnitudes against the limits
    assign speed_err  = abs_err(item.target_speed, item.measured_speed);
    assign angle_err  = abs_err(item.target_angle, item.measured_angle);
    assign speed_over = speed_err > cfg.speed_error_limit;
    assign angle_over = angle_err > cfg.angle_error_limit;

    // Candidate counter values if the check runs this tick
    assign speed_cnt = !speed_over ? 8'd0 :
                       (speed_dev_ticks_reg == DEV_TICKS_MAX) ? DEV_TICKS_MAX :
                       speed_dev_ticks_reg + 8'd1;
    assign angle_cnt = angle_over ? angle_dev_ticks_reg + 8'd1 : 8'd0;  // wraps
    assign front_cnt = (front_mode_ticks_reg == FRONT_TICKS_MAX) ? FRONT_TICKS_MAX :
                       front_mode_ticks_reg + 16'd1;

    assign speed_fault = speed_cnt > cfg.persist_limit;
    assign angle_fault = angle_cnt > cfg.persist_limit;
    assign front_fault = front_cnt > cfg.front_time_limit;

    // Per-mode decision and counter updates
    always_comb
    begin
        fault_next            = 1'b0;
        speed_dev_ticks_next  = speed_dev_ticks_reg;
        angle_dev_ticks_next  = angle_dev_ticks_reg;
        front_mode_ticks_next = front_mode_ticks_reg;
        unique case (item.mode)
            MODE_TRACK:
            begin
                speed_dev_ticks_next  = speed_cnt;
                front_mode_ticks_next = 16'd0;
                // angle check is skipped once speed has flagged
                if (speed_fault)
                begin
                    fault_next = 1'b1;
                end
                else
                begin
                    angle_dev_ticks_next = angle_cnt;
                    fault_next           = angle_fault;
                end
            end
            MODE_SIDE:
            begin
                speed_dev_ticks_next  = speed_cnt;
                angle_dev_ticks_next  = 8'd0;
                front_mode_ticks_next = 16'd0;
                fault_next            = speed_fault;
            end
            MODE_FRONT:
            begin
                speed_dev_ticks_next  = 8'd0;
                angle_dev_ticks_next  = 8'd0;
                front_mode_ticks_next = front_cnt;
                fault_next            = front_fault;
            end
            MODE_NONE:
            begin
                fault_next = 1'b0;
            end
            default:
            begin
                fault_next = 1'b0;
            end
        endcase
    end

    // Counters advance only when an item is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_dev_ticks_reg  <= 8'd0;
            angle_dev_ticks_reg  <= 8'd0;
            front_mode_ticks_reg <= 16'd0;
        end
        else if (step)
        begin
            speed_dev_ticks_reg  <= speed_dev_ticks_next;
            angle_dev_ticks_reg  <= angle_dev_ticks_next;
            front_mode_ticks_reg <= front_mode_ticks_next;
        end
    end

`ifndef ASSERT_OFF
    // No-control ticks leave every counter alone
    a_none_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.mode == MODE_NONE) |=>
            ($stable(speed_dev_ticks_reg) && $stable(angle_dev_ticks_reg)
             && $stable(front_mode_ticks_reg)))
        else $error("counters changed on a no-control tick");

    // Front-wall ticks clear both persistence counters
    a_front_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.mode == MODE_FRONT) |=>
            (speed_dev_ticks_reg == 8'd0 && angle_dev_ticks_reg == 8'd0))
        else $error("persistence counters not cleared in front-wall mode");

    // Tracking and side-wall ticks clear the front-wall timer
    a_wall_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.mode == MODE_TRACK || item.mode == MODE_SIDE)) |=>
            (front_mode_ticks_reg == 16'd0))
        else $error("front-wall timer not cleared");

    // A side-wall fault needs a nonzero speed counter
    a_side_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.mode == MODE_SIDE && fault_next) |=>
            (speed_dev_ticks_reg != 8'd0))
        else $error("side-wall fault with idle speed counter");
`endif

endmodule

[hdl/motion_fault_watchdog.sv]
// Top level of the motion fault watchdog: item handshake and result register.
// Each item is one control tick; the block answers with one fault bit per
// item, in order. An item is registered in the input register on acceptance,
// and its fault bit moves into the result register once that slot is free,
// and a new item is accepted every cycle as long as the result side keeps
// up. The rate is set by the per-tick counter update, which is combinational.
// The user must write limits through the configuration port only while no
// item is in flight; the block does not enforce this. After reset they read
// speed 512, angle 512, persistence 100 and front-wall time 1000, and all counters are zero.
module motion_fault_watchdog
    import mfw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic signed [15:0]    target_speed,
    input  logic signed [15:0]    measured_speed,
    input  logic signed [15:0]    target_angle,
    input  logic signed [15:0]    measured_angle,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  fault
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    logic  fault_reg;
    logic  fault_next;
    logic  advance;
    logic  in_take;

    mfw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: item moves to the result register when that slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    mfw_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (item_reg),
        .cfg        (cfg),
        .fault_next (fault_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode           <= mode_t'(mode);
            item_reg.target_speed   <= target_speed;
            item_reg.measured_speed <= measured_speed;
            item_reg.target_angle   <= target_angle;
            item_reg.measured_angle <= measured_angle;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fault_reg <= fault_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fault     = fault_reg;

endmodule

[tb/mfw_checker.sv]
// Scoreboard for the motion fault watchdog: predicts each tick's fault bit and checks results.
`timescale 1ns / 100ps

module mfw_checker
    import mfw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic signed [15:0]    target_speed,
    input  logic signed [15:0]    measured_speed,
    input  logic signed [15:0]    target_angle,
    input  logic signed [15:0]    measured_angle,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  fault,
    output int                    err_cnt,
    output int                    pending_cnt,
    output int                    fault_cnt
);

    // Deviation run counters kept by the watchdog
    typedef struct packed {
        logic [7:0]  speed_run;
        logic [7:0]  angle_run;
        logic [15:0] front_run;
    } run_counters_t;

    typedef struct packed {
        run_counters_t next;
        logic          fault;
    } tick_outcome_t;

    cfg_t          limits;
    run_counters_t runs;
    tick_outcome_t outcome;
    logic          want_fault;
    logic          fault_q [$];
    int            errs;
    int            faults;

    // |tgt - meas| computed exactly, strictly above the limit
    function automatic logic exceeds(input logic signed [15:0] tgt,
                                     input logic signed [15:0] meas,
                                     input logic [15:0] limit);
        int diff;
        diff = int'(tgt) - int'(meas);
        if (diff < 0)
            diff = -diff;
        return diff > int'(limit);
    endfunction

    // Next counters and fault bit for one tick
    function automatic tick_outcome_t predict_tick(input cfg_t lim, input run_counters_t cnt,
                                                   input mode_t m,
                                                   input logic signed [15:0] ts,
                                                   input logic signed [15:0] ms,
                                                   input logic signed [15:0] ta,
                                                   input logic signed [15:0] ma);
        tick_outcome_t o;
        o.next  = cnt;
        o.fault = 1'b0;
        case (m)
            MODE_TRACK, MODE_SIDE:
            begin
                // speed run saturates
                if (exceeds(ts, ms, lim.speed_error_limit))
                begin
                    if (o.next.speed_run != DEV_TICKS_MAX)
                        o.next.speed_run = o.next.speed_run + 8'd1;
                end
                else
                    o.next.speed_run = 8'd0;
                o.fault = o.next.speed_run > lim.persist_limit;
                // tracking checks angle only when speed is fine; angle run wraps
                if (m == MODE_TRACK)
                begin
                    if (!o.fault)
                    begin
                        if (exceeds(ta, ma, lim.angle_error_limit))
                            o.next.angle_run = o.next.angle_run + 8'd1;
                        else
                            o.next.angle_run = 8'd0;
                        o.fault = o.next.angle_run > lim.persist_limit;
                    end
                end
                else
                    o.next.angle_run = 8'd0;
                o.next.front_run = 16'd0;
            end
            MODE_FRONT:
            begin
                if (o.next.front_run != FRONT_TICKS_MAX)
                    o.next.front_run = o.next.front_run + 16'd1;
                o.fault           = o.next.front_run > lim.front_time_limit;
                o.next.speed_run  = 8'd0;
                o.next.angle_run  = 8'd0;
            end
            default:
            begin
                // no control: counters hold
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits.speed_error_limit = SPEED_LIMIT_RST;
            limits.angle_error_limit = ANGLE_LIMIT_RST;
            limits.persist_limit     = PERSIST_LIMIT_RST;
            limits.front_time_limit  = FRONT_LIMIT_RST;
            runs   = '0;
            fault_q.delete();
            errs   = 0;
            faults = 0;
            err_cnt     <= 0;
            pending_cnt <= 0;
            fault_cnt   <= 0;
        end
        else
        begin
            // mirror limit writes
            if (cfg_wr_en)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SPEED_LIMIT:   limits.speed_error_limit = cfg_data[15:0];
                    CFG_ANGLE_LIMIT:   limits.angle_error_limit = cfg_data[15:0];
                    CFG_PERSIST_LIMIT: limits.persist_limit     = cfg_data[7:0];
                    CFG_FRONT_LIMIT:   limits.front_time_limit  = cfg_data[15:0];
                    default:           ;
                endcase
            end

            // compare each result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (fault_q.size() == 0)
                begin
                    $error("fault: result with no item pending, actual %0b", fault);
                    errs++;
                end
                else
                begin
                    want_fault = fault_q.pop_front();
                    if (fault !== want_fault)
                    begin
                        $error("fault mismatch: expected %0b, actual %0b", want_fault, fault);
                        errs++;
                    end
                end
                if (fault === 1'b1)
                    faults++;
            end

            // predict each accepted item
            if (in_valid && in_ready)
            begin
                outcome = predict_tick(limits, runs, mode_t'(mode), target_speed,
                                       measured_speed, target_angle, measured_angle);
                runs = outcome.next;
                fault_q.push_back(outcome.fault);
            end

            err_cnt     <= errs;
            pending_cnt <= fault_q.size();
            fault_cnt   <= faults;
        end
    end

endmodule

[tb/tb_motion_fault_watchdog.sv]
// Testbench top for the motion fault watchdog: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_motion_fault_watchdog;
    import mfw_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic signed [15:0]    target_speed;
    logic signed [15:0]    measured_speed;
    logic signed [15:0]    target_angle;
    logic signed [15:0]    measured_angle;
    logic                  out_valid;
    logic                  out_ready;
    logic                  fault;

    int err_cnt;
    int pending_cnt;
    int fault_cnt;

    int   burst_left;
    int   ticks_sent;
    int   settings_cnt;
    logic sender_idles;

    logic [15:0] cur_speed_lim;
    logic [15:0] cur_angle_lim;
    logic [7:0]  cur_persist;
    logic [15:0] cur_front_lim;

    typedef enum {RX_OPEN, RX_MOSTLY, RX_TOGGLE, RX_COIN} rx_style_t;

    motion_fault_watchdog u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fault          (fault)
    );

    mfw_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .target_speed   (target_speed),
        .measured_speed (measured_speed),
        .target_angle   (target_angle),
        .measured_angle (measured_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .fault          (fault),
        .err_cnt        (err_cnt),
        .pending_cnt    (pending_cnt),
        .fault_cnt      (fault_cnt)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: changing ready pattern plus two long hold-offs
    initial
    begin : rx_pattern
        int        cyc;
        int        hold_left;
        rx_style_t style;
        out_ready = 1'b1;
        cyc       = 0;
        hold_left = 0;
        style     = RX_OPEN;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                style = rx_style_t'($urandom_range(3));
            if (cyc == 400 || cyc == 1800)
                hold_left = 80;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_MOSTLY: out_ready <= ($urandom_range(3) != 0);
                    RX_TOGGLE: out_ready <= cyc[0];
                    default:   out_ready <= 1'($urandom_range(1));
                endcase
            end
        end
    end

    // Offer one item, with burst/gap idling, and wait for acceptance
    task automatic send_tick(input logic [1:0] m, input logic [15:0] ts, input logic [15:0] ms,
                             input logic [15:0] ta, input logic [15:0] ma);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = sender_idles ? $urandom_range(5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        mode           <= m;
        target_speed   <= ts;
        measured_speed <= ms;
        target_angle   <= ta;
        measured_angle <= ma;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        burst_left--;
        ticks_sent++;
    endtask

    // Stop offering and wait until every fault bit has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
    endtask

    // Settle, then load all four limits
    task automatic write_limits(input logic [15:0] spd, input logic [15:0] ang,
                                input logic [7:0] per, input logic [15:0] frt);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPEED_LIMIT;
        cfg_data  <= spd;
        @(posedge clk);
        cfg_index <= CFG_ANGLE_LIMIT;
        cfg_data  <= ang;
        @(posedge clk);
        cfg_index <= CFG_PERSIST_LIMIT;
        cfg_data  <= {8'd0, per};
        @(posedge clk);
        cfg_index <= CFG_FRONT_LIMIT;
        cfg_data  <= frt;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_speed_lim = spd;
        cur_angle_lim = ang;
        cur_persist   = per;
        cur_front_lim = frt;
        settings_cnt++;
    endtask

    // {a, b} with |a - b| above or within the limit, often right at the edge
    function automatic logic [31:0] pick_pair(input logic [15:0] limit, input logic dev);
        int e;
        int t;
        int m;
        if (dev && limit != 16'hFFFF)
            e = ($urandom_range(7) == 0) ? int'(limit) + 1
                                         : int'($urandom_range(65535, int'(limit) + 1));
        else
            e = ($urandom_range(7) == 0) ? int'(limit) : int'($urandom_range(int'(limit), 0));
        t = int'($urandom_range(65535 - e)) - 32768 + e;
        m = t - e;
        if ($urandom_range(1) == 0)
            return {t[15:0], m[15:0]};
        else
            return {m[15:0], t[15:0]};
    endfunction

    // Same mode for n ticks with fixed deviation pattern
    task automatic run_steady(input logic [1:0] m, input int n, input logic sdev,
                              input logic adev);
        logic [31:0] sp;
        logic [31:0] ap;
        int          i;
        for (i = 0; i < n; i++)
        begin
            sp = pick_pair(cur_speed_lim, sdev);
            ap = pick_pair(cur_angle_lim, adev);
            send_tick(m, sp[31:16], sp[15:0], ap[31:16], ap[15:0]);
        end
    endtask

    // Mostly mode runs of up to the limit plus 4 ticks (limit capped at 100), some raw noise
    task automatic run_random(input int n);
        int          done_cnt;
        int          len;
        int          cap;
        int          s_pct;
        int          a_pct;
        int          r;
        int          i;
        logic [1:0]  m;
        logic [31:0] sp;
        logic [31:0] ap;
        sender_idles = ($urandom_range(3) != 0);
        done_cnt     = 0;
        while (done_cnt < n)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_tick(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
                done_cnt++;
            end
            else
            begin
                r = $urandom_range(99);
                m = (r < 35) ? MODE_TRACK : (r < 60) ? MODE_SIDE :
                    (r < 85) ? MODE_FRONT : MODE_NONE;
                cap = (m == MODE_FRONT) ? int'(cur_front_lim) : int'(cur_persist);
                if (cap > 100)
                    cap = 100;
                len = $urandom_range(cap + 4, 1);
                r = $urandom_range(2);
                s_pct = (r == 0) ? 95 : (r == 1) ? 50 : 5;
                r = $urandom_range(2);
                a_pct = (r == 0) ? 95 : (r == 1) ? 50 : 5;
                for (i = 0; i < len; i++)
                begin
                    sp = pick_pair(cur_speed_lim, $urandom_range(99) < s_pct);
                    ap = pick_pair(cur_angle_lim, $urandom_range(99) < a_pct);
                    send_tick(m, sp[31:16], sp[15:0], ap[31:16], ap[15:0]);
                end
                done_cnt += len;
            end
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_SPEED_LIMIT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = MODE_NONE;
        target_speed   = '0;
        measured_speed = '0;
        target_angle   = '0;
        measured_angle = '0;
        burst_left     = 0;
        ticks_sent     = 0;
        settings_cnt   = 0;
        sender_idles   = 1'b1;
        cur_speed_lim  = SPEED_LIMIT_RST;
        cur_angle_lim  = ANGLE_LIMIT_RST;
        cur_persist    = PERSIST_LIMIT_RST;
        cur_front_lim  = FRONT_LIMIT_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset limits first, speed error right at and just past 512
        send_tick(MODE_NONE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_tick(MODE_SIDE, 16'h0200, 16'h0000, 16'h0000, 16'h0000);
        send_tick(MODE_SIDE, 16'h0000, 16'hFDFF, 16'h0000, 16'h0000);

        // Directed: tight persistence and front-wall time
        write_limits(16'd512, 16'd512, 8'd2, 16'd3);
        run_steady(MODE_SIDE, 3, 1'b1, 1'b0);
        // speed already faulting: angle check skipped
        send_tick(MODE_TRACK, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_tick(MODE_NONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(MODE_SIDE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_steady(MODE_TRACK, 4, 1'b0, 1'b1);
        send_tick(MODE_FRONT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_steady(MODE_FRONT, 4, 1'b0, 1'b0);
        // no-control tick keeps the front-wall count
        send_tick(MODE_NONE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_tick(MODE_FRONT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_tick(MODE_TRACK, 16'h0100, 16'h0100, 16'hFF00, 16'hFF00);
        send_tick(MODE_FRONT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_steady(MODE_TRACK, 3, 1'b1, 1'b1);

        // Random phases across limit settings, extremes included
        write_limits(16'd0, 16'd0, 8'd0, 16'd0);
        run_random(40);
        write_limits(SPEED_LIMIT_RST, ANGLE_LIMIT_RST, PERSIST_LIMIT_RST, FRONT_LIMIT_RST);
        run_random(40);
        write_limits(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
        run_random(40);
        write_limits(16'd256, 16'd1024, 8'd3, 16'd5);
        run_random(40);
        write_limits(16'd1, 16'd65534, 8'd1, 16'd1);
        run_random(40);
        write_limits(16'd4096, 16'd300, 8'd7, 16'd20);
        run_random(40);
        write_limits(16'd65534, 16'd0, 8'd0, 16'd65534);
        run_random(40);
        write_limits(16'd1000, 16'd1000, 8'd255, 16'd2);
        run_random(40);

        // Speed run saturating at 255, angle run wrapping past 255
        write_limits(16'd100, 16'd100, 8'd254, 16'd10);
        sender_idles = 1'b1;
        run_steady(MODE_SIDE, 262, 1'b1, 1'b0);
        run_steady(MODE_TRACK, 262, 1'b0, 1'b1);

        // Front-wall count running past a mid-range limit
        write_limits(16'd512, 16'd512, 8'd100, 16'd15);
        sender_idles = 1'b0;
        run_steady(MODE_FRONT, 20, 1'b0, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        $display("Covered %0d ticks over %0d limit settings, all modes; %0d faults raised.",
                 ticks_sent, settings_cnt, fault_cnt);
        $display("Included counter saturation and wrap, and two long result-side stalls.");
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
hdl/mfw_pkg.sv
hdl/mfw_cfg.sv
hdl/mfw_eval.sv
hdl/motion_fault_watchdog.sv
tb/mfw_checker.sv
tb/tb_motion_fault_watchdog.sv
